// ===== design/ptc_pkg.sv =====
// shared types and constants of the pid turn controller
`default_nettype none
package ptc_pkg;

	// register reset values
	localparam logic [11:0] GAIN_P_RST            = 12'd614;
	localparam logic [11:0] GAIN_I_RST            = 12'd5;
	localparam logic [11:0] GAIN_D_RST            = 12'd51;
	localparam logic [7:0]  SETTLE_THRESHOLD_RST  = 8'd2;
	localparam logic [7:0]  SETTLE_TICKS_RST      = 8'd42;
	localparam logic [11:0] TIMEOUT_TICKS_RST     = 12'd250;
	localparam logic [8:0]  INTEG_RESET_TICKS_RST = 9'd300;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_GAIN_P            = 3'd0;
	localparam logic [2:0] REG_GAIN_I            = 3'd1;
	localparam logic [2:0] REG_GAIN_D            = 3'd2;
	localparam logic [2:0] REG_SETTLE_THRESHOLD  = 3'd3;
	localparam logic [2:0] REG_SETTLE_TICKS      = 3'd4;
	localparam logic [2:0] REG_TIMEOUT_TICKS     = 3'd5;
	localparam logic [2:0] REG_INTEG_RESET_TICKS = 3'd6;

	// integral saturation bounds
	localparam logic [23:0] INTEG_MAX = 24'h7FFFFF;
	localparam logic [23:0] INTEG_MIN = 24'h800000;

	// datapath widths
	localparam int ACC_W  = 38;
	localparam int MAG_W  = 37;
	localparam int PROD_W = 44;
	localparam int REM_W  = 22;

	// output scale divisor 127 * 256 and the product at which the drive saturates
	localparam logic [REM_W-1:0]  DIV_K    = 22'd32512;
	localparam logic [PROD_W-1:0] SAT_PROD = 44'd4161536;
	localparam logic [6:0]        DRIVE_MAX = 7'd127;

	// operands handed to the arithmetic unit
	typedef struct packed {
		logic        go;
		logic [12:0] err;
		logic [13:0] diff;
		logic [23:0] integ;
		logic [6:0]  speed;
	} ptc_req_t;

	// result from the arithmetic unit
	typedef struct packed {
		logic       done;
		logic [7:0] drive;
	} ptc_rsp_t;

endpackage
`default_nettype wire

// ===== design/ptc_arith.sv =====
// bit-serial pid sum, speed scaling and divide with saturation
`default_nettype none
module ptc_arith (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [11:0]       gain_p,
	input  wire logic [11:0]       gain_i,
	input  wire logic [11:0]       gain_d,
	input  wire ptc_pkg::ptc_req_t req,
	output ptc_pkg::ptc_rsp_t      rsp
);

	typedef enum logic [2:0] {
		U_IDLE,
		U_PID,
		U_ABS,
		U_SCALE,
		U_RANGE,
		U_DIV
	} ustate_t;

	ustate_t                         state_q;
	logic [3:0]                      cnt_q;
	logic [ptc_pkg::ACC_W-1:0]       acc_q;
	logic [ptc_pkg::MAG_W-1:0]       mag_q;
	logic                            neg_q;
	logic [ptc_pkg::PROD_W-1:0]      prod_q;
	logic [6:0]                      quo_q;
	logic [7:0]                      drive_q;
	logic                            done_q;

	logic [ptc_pkg::ACC_W-1:0]       te, td, ti, acc_step;
	logic [ptc_pkg::MAG_W-1:0]       mag_abs;
	logic [ptc_pkg::PROD_W-1:0]      mag_add, prod_step;
	logic [ptc_pkg::REM_W-1:0]       cand, rem_sub;
	logic                            rem_ge;
	logic [6:0]                      quo_next;

	// signed drive from magnitude and sign
	function automatic logic [7:0] to_drive(input logic neg, input logic [6:0] m);
		logic [7:0] v;
		v = {1'b0, m};
		return neg ? 8'(~v + 8'd1) : v;
	endfunction

	// one gain bit per cycle, msb first, for all three terms at once
	always_comb begin
		te = gain_p[cnt_q] ? {{25{req.err[12]}}, req.err} : '0;
		td = gain_d[cnt_q] ? {{24{req.diff[13]}}, req.diff} : '0;
		ti = gain_i[cnt_q] ? {{14{req.integ[23]}}, req.integ} : '0;
		acc_step = {acc_q[ptc_pkg::ACC_W-2:0], 1'b0} + te + td + ti;
	end

	// magnitude of the pid sum
	assign mag_abs = acc_q[ptc_pkg::ACC_W-1] ?
		ptc_pkg::MAG_W'(~acc_q + 38'd1) : acc_q[ptc_pkg::MAG_W-1:0];

	// one speed bit per cycle
	always_comb begin
		mag_add = req.speed[cnt_q[2:0]] ? {7'b0, mag_q} : '0;
		prod_step = {prod_q[ptc_pkg::PROD_W-2:0], 1'b0} + mag_add;
	end

	// restoring divide, one quotient bit per cycle
	always_comb begin
		cand = ptc_pkg::DIV_K << cnt_q[2:0];
		rem_ge = prod_q[ptc_pkg::REM_W-1:0] >= cand;
		rem_sub = prod_q[ptc_pkg::REM_W-1:0] - cand;
		quo_next = quo_q | (rem_ge ? (7'd1 << cnt_q[2:0]) : 7'd0);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				U_IDLE: begin
					done_q <= 1'b0;
					if (req.go) begin
						acc_q   <= '0;
						cnt_q   <= 4'd11;
						state_q <= U_PID;
					end
				end
				U_PID: begin
					acc_q <= acc_step;
					if (cnt_q == 4'd0) begin
						state_q <= U_ABS;
					end else begin
						cnt_q <= cnt_q - 4'd1;
					end
				end
				U_ABS: begin
					neg_q   <= acc_q[ptc_pkg::ACC_W-1];
					mag_q   <= mag_abs;
					prod_q  <= '0;
					cnt_q   <= 4'd6;
					state_q <= U_SCALE;
				end
				U_SCALE: begin
					prod_q <= prod_step;
					if (cnt_q == 4'd0) begin
						state_q <= U_RANGE;
					end else begin
						cnt_q <= cnt_q - 4'd1;
					end
				end
				U_RANGE: begin
					if (prod_q >= ptc_pkg::SAT_PROD) begin
						drive_q <= to_drive(neg_q, ptc_pkg::DRIVE_MAX);
						done_q  <= 1'b1;
						state_q <= U_IDLE;
					end else begin
						quo_q   <= '0;
						cnt_q   <= 4'd6;
						state_q <= U_DIV;
					end
				end
				U_DIV: begin
					quo_q <= quo_next;
					prod_q <= {prod_q[ptc_pkg::PROD_W-1:ptc_pkg::REM_W],
						rem_ge ? rem_sub : prod_q[ptc_pkg::REM_W-1:0]};
					if (cnt_q == 4'd0) begin
						drive_q <= to_drive(neg_q, quo_next);
						done_q  <= 1'b1;
						state_q <= U_IDLE;
					end else begin
						cnt_q <= cnt_q - 4'd1;
					end
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= U_IDLE;
				end
			endcase
		end
	end

	assign rsp.done  = done_q;
	assign rsp.drive = drive_q;

endmodule
`default_nettype wire

// ===== design/pid_turn_controller_core.sv =====
// pid turn controller: tick bookkeeping, config registers and result register
//
// Usage: each control tick is one transaction on the item channel (item_valid,
// item_stall) carrying start_req, target_deg, speed_limit and gyro_deg. Every
// tick yields exactly one transaction on the result channel (res_valid,
// res_stall) with left_drive, right_drive and done_res.
// A tick that drives the motors runs through the bit-serial arithmetic unit:
// the gain bits of the pid sum, then the speed bits, then the quotient bits of
// the divide by 127*256, with hand-off states between them; the divide is
// skipped when the drive saturates. An idle or finishing tick bypasses the
// arithmetic unit. One tick is in work at a time; the next tick is taken as
// soon as the previous result sits in the output register. Reset clears the
// run state, loads the register defaults and leaves the controller inactive,
// so ticks report zero drive and done until a start. When the receiver stalls,
// the result register holds its transaction; a finished second result waits
// inside and item_stall stays high meanwhile. Registers are written over the
// apb port at byte address 4*index; the user must write them only while idle,
// which the block itself does not enforce.
`default_nettype none
module pid_turn_controller_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// config port
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [4:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	// tick channel
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire logic              start_req,
	input  wire logic [11:0]       target_deg,
	input  wire logic [6:0]        speed_limit,
	input  wire logic signed [12:0] gyro_deg,
	// result channel
	output logic                   res_valid,
	input  wire logic              res_stall,
	output logic signed [7:0]      left_drive,
	output logic signed [7:0]      right_drive,
	output logic                   done_res
);

	typedef enum logic [1:0] {
		T_IDLE,
		T_CALC,
		T_OUT
	} tstate_t;

	// config registers
	logic [11:0] gain_p_q, gain_i_q, gain_d_q, timeout_ticks_q;
	logic [7:0]  settle_threshold_q, settle_ticks_q;
	logic [8:0]  integ_reset_ticks_q;

	// run state
	logic        active_q;
	logic [11:0] target_q;
	logic [6:0]  speed_q;
	logic [23:0] integ_q;
	logic [12:0] prev_q;
	logic [8:0]  icnt_q;
	logic [11:0] elapsed_q;
	logic [7:0]  settle_q;

	// control and output
	tstate_t            state_q;
	ptc_pkg::ptc_req_t  req_q;
	ptc_pkg::ptc_rsp_t  rsp;
	logic [7:0]         pend_left_q;
	logic               pend_done_q;
	logic               res_valid_q;
	logic [7:0]         left_q, right_q;
	logic               done_q;

	// tick evaluation
	logic        accept, cfg_wr;
	logic        act_eff;
	logic [11:0] tgt_eff;
	logic [6:0]  spd_eff;
	logic [23:0] integ_base;
	logic [12:0] prev_base;
	logic [8:0]  icnt_base, icnt_inc;
	logic [11:0] el_base, el_new;
	logic [7:0]  settle_base, settle_new;
	logic [12:0] gyro_mag, err, aerr;
	logic [13:0] err_w, diff;
	logic [24:0] integ_sum;
	logic [23:0] integ_sat;
	logic        on_tgt, fin, icnt_clr;
	logic        out_free;

	assign accept = item_valid && !item_stall;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign out_free = !res_valid_q || !res_stall;

	// state seen by this tick, after an optional start
	always_comb begin
		act_eff     = start_req ? 1'b1 : active_q;
		tgt_eff     = start_req ? target_deg : target_q;
		spd_eff     = start_req ? speed_limit : speed_q;
		integ_base  = start_req ? '0 : integ_q;
		prev_base   = start_req ? '0 : prev_q;
		icnt_base   = start_req ? '0 : icnt_q;
		el_base     = start_req ? '0 : elapsed_q;
		settle_base = start_req ? '0 : settle_q;
	end

	// error, integral and counters
	always_comb begin
		gyro_mag = gyro_deg[12] ? 13'(~gyro_deg + 13'sd1) : gyro_deg;
		err_w = {2'b00, tgt_eff} - {1'b0, gyro_mag};
		err = err_w[12:0];
		aerr = err[12] ? 13'(~err + 13'd1) : err;
		diff = {err[12], err} - {prev_base[12], prev_base};
		integ_sum = {integ_base[23], integ_base} + {{12{err[12]}}, err};
		if (integ_sum[24] != integ_sum[23]) begin
			integ_sat = integ_sum[24] ? ptc_pkg::INTEG_MIN : ptc_pkg::INTEG_MAX;
		end else begin
			integ_sat = integ_sum[23:0];
		end
		icnt_inc = icnt_base + 9'd1;
		icnt_clr = icnt_inc >= integ_reset_ticks_q;
		on_tgt = aerr < {5'b0, settle_threshold_q};
		if (!on_tgt) begin
			settle_new = '0;
		end else if (settle_base != 8'hFF) begin
			settle_new = settle_base + 8'd1;
		end else begin
			settle_new = settle_base;
		end
		el_new = (el_base != 12'hFFF) ? el_base + 12'd1 : el_base;
		fin = (on_tgt && settle_new >= settle_ticks_q) || (el_new >= timeout_ticks_q);
	end

	// config register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q            <= ptc_pkg::GAIN_P_RST;
			gain_i_q            <= ptc_pkg::GAIN_I_RST;
			gain_d_q            <= ptc_pkg::GAIN_D_RST;
			settle_threshold_q  <= ptc_pkg::SETTLE_THRESHOLD_RST;
			settle_ticks_q      <= ptc_pkg::SETTLE_TICKS_RST;
			timeout_ticks_q     <= ptc_pkg::TIMEOUT_TICKS_RST;
			integ_reset_ticks_q <= ptc_pkg::INTEG_RESET_TICKS_RST;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				ptc_pkg::REG_GAIN_P:            gain_p_q            <= pwdata[11:0];
				ptc_pkg::REG_GAIN_I:            gain_i_q            <= pwdata[11:0];
				ptc_pkg::REG_GAIN_D:            gain_d_q            <= pwdata[11:0];
				ptc_pkg::REG_SETTLE_THRESHOLD:  settle_threshold_q  <= pwdata[7:0];
				ptc_pkg::REG_SETTLE_TICKS:      settle_ticks_q      <= pwdata[7:0];
				ptc_pkg::REG_TIMEOUT_TICKS:     timeout_ticks_q     <= pwdata[11:0];
				ptc_pkg::REG_INTEG_RESET_TICKS: integ_reset_ticks_q <= pwdata[8:0];
				default: begin
				end
			endcase
		end
	end

	// config read-back
	always_comb begin
		case (paddr[4:2])
			ptc_pkg::REG_GAIN_P:            prdata = {20'b0, gain_p_q};
			ptc_pkg::REG_GAIN_I:            prdata = {20'b0, gain_i_q};
			ptc_pkg::REG_GAIN_D:            prdata = {20'b0, gain_d_q};
			ptc_pkg::REG_SETTLE_THRESHOLD:  prdata = {24'b0, settle_threshold_q};
			ptc_pkg::REG_SETTLE_TICKS:      prdata = {24'b0, settle_ticks_q};
			ptc_pkg::REG_TIMEOUT_TICKS:     prdata = {20'b0, timeout_ticks_q};
			ptc_pkg::REG_INTEG_RESET_TICKS: prdata = {23'b0, integ_reset_ticks_q};
			default:                        prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	// tick sequencer, run state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			req_q.go    <= 1'b0;
			active_q    <= 1'b0;
			target_q    <= '0;
			speed_q     <= '0;
			integ_q     <= '0;
			prev_q      <= '0;
			icnt_q      <= '0;
			elapsed_q   <= '0;
			settle_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// kick the arithmetic unit for an active tick that does not finish
			req_q.go <= accept && act_eff && !fin;
			if (res_valid_q && !res_stall && state_q != T_OUT) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				T_IDLE: begin
					if (accept) begin
						if (!act_eff) begin
							pend_left_q <= '0;
							pend_done_q <= 1'b1;
							state_q     <= T_OUT;
						end else begin
							target_q  <= tgt_eff;
							speed_q   <= spd_eff;
							prev_q    <= err;
							settle_q  <= settle_new;
							elapsed_q <= el_new;
							integ_q   <= icnt_clr ? '0 : integ_sat;
							icnt_q    <= icnt_clr ? '0 : icnt_inc;
							active_q  <= !fin;
							req_q.err   <= err;
							req_q.diff  <= diff;
							req_q.integ <= integ_sat;
							req_q.speed <= spd_eff;
							if (fin) begin
								pend_left_q <= '0;
								pend_done_q <= 1'b1;
								state_q     <= T_OUT;
							end else begin
								state_q  <= T_CALC;
							end
						end
					end
				end
				T_CALC: begin
					if (rsp.done) begin
						pend_left_q <= rsp.drive;
						pend_done_q <= 1'b0;
						state_q     <= T_OUT;
					end
				end
				T_OUT: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						left_q      <= pend_left_q;
						right_q     <= 8'(~pend_left_q + 8'd1);
						done_q      <= pend_done_q;
						state_q     <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	// serial arithmetic
	ptc_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.gain_p (gain_p_q),
		.gain_i (gain_i_q),
		.gain_d (gain_d_q),
		.req    (req_q),
		.rsp    (rsp)
	);

	assign item_stall  = (state_q != T_IDLE);
	assign res_valid   = res_valid_q;
	assign left_drive  = left_q;
	assign right_drive = right_q;
	assign done_res    = done_q;

endmodule
`default_nettype wire
